>>> src/qmn_pkg.sv
// shared types and constants for the quaternion multiply and normalise unit
package qmn_pkg;

  localparam int CompW     = 16;
  localparam int ProdW     = 32;
  localparam int SumW      = 34;
  localparam int MagW      = 33;
  localparam int ScaleW    = 31;
  localparam int SqW       = 62;
  localparam int AccW      = 64;
  localparam int RootW     = 32;
  localparam int FracBits  = 14;
  localparam int RemW      = 47;
  localparam int QuoW      = 16;
  localparam int SqrtIter  = 32;
  localparam int SqrtPer   = 2;
  localparam int SqrtStg   = SqrtIter / SqrtPer;
  localparam int DivPer    = 2;
  localparam int DivStg    = QuoW / DivPer;
  localparam int FrontStg  = 7;

  typedef struct packed {
    logic signed [CompW-1:0] left_x;
    logic signed [CompW-1:0] left_y;
    logic signed [CompW-1:0] left_z;
    logic signed [CompW-1:0] left_w;
    logic signed [CompW-1:0] right_x;
    logic signed [CompW-1:0] right_y;
    logic signed [CompW-1:0] right_z;
    logic signed [CompW-1:0] right_w;
  } in_t;

  typedef struct packed {
    logic signed [CompW-1:0] prod_x;
    logic signed [CompW-1:0] prod_y;
    logic signed [CompW-1:0] prod_z;
    logic signed [CompW-1:0] prod_w;
    logic                    zero_length;
  } out_t;

  // per-item side data that rides along the root and divide stages
  typedef struct packed {
    logic [3:0]             neg;
    logic                   zero;
    logic [3:0][ScaleW-1:0] mag;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic [AccW-1:0] rem;
    logic [AccW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    side_t                side;
    logic [RootW-1:0]     r;
    logic [3:0][RemW-1:0] rem;
    logic [3:0][QuoW-1:0] quo;
  } div_t;

endpackage

>>> src/quaternion_multiply_normalize_unit.sv
// Hamilton product of two Q2.14 quaternions, normalised to unit length.
// Fully pipelined: one item may enter every cycle while the output is not
// held. Each item runs through the 7 product/scaling stages, the
// 16-stage integer square root (two root bits per stage), the 8-stage
// divide (two quotient bits per stage, four lanes side by side) and the
// output register. The whole pipeline holds while a result waits on the
// output; empty stages hold all the same. A zero product gives all-zero
// components with zero_length set.
module quaternion_multiply_normalize_unit
  import qmn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic en;
  logic [FrontStg-1:0] vfront_r;
  logic [SqrtStg-1:0]  vsq_r;
  logic [DivStg-1:0]   vdv_r;
  logic                out_valid_r;
  out_t                out_r;
  out_t                out_nxt;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stage 1: sixteen products
  logic signed [ProdW-1:0] p_r [16];
  // stage 2: raw components as sign and magnitude
  logic [3:0]          neg2_r;
  logic [MagW-1:0]     mag2_r [4];
  logic signed [SumW-1:0] c_nxt [4];
  // stage 3: largest magnitude
  logic [3:0]          neg3_r;
  logic [MagW-1:0]     mag3_r [4];
  logic [MagW-1:0]     max3_r;
  logic [MagW-1:0]     max_nxt;
  // stage 4: bit length of the largest magnitude
  logic [3:0]          neg4_r;
  logic [MagW-1:0]     mag4_r [4];
  logic [5:0]          n4_r;
  logic                zero4_r;
  logic [5:0]          n_nxt;
  // stage 5: block-scaled magnitudes
  side_t               side5_r;
  side_t               side5_nxt;
  // stage 6: squares
  side_t               side6_r;
  logic [SqW-1:0]      sq6_r [4];
  // stage 7: sum of squares
  side_t               side7_r;
  logic [AccW-1:0]     s7_r;

  sqrt_t sq_r   [SqrtStg];
  sqrt_t sq_nxt [SqrtStg];
  div_t  dv_r   [DivStg];
  div_t  dv_nxt [DivStg];

  always_comb begin
    c_nxt[0] = SumW'(p_r[0]) + SumW'(p_r[1]) + SumW'(p_r[2]) - SumW'(p_r[3]);
    c_nxt[1] = SumW'(p_r[4]) + SumW'(p_r[5]) + SumW'(p_r[6]) - SumW'(p_r[7]);
    c_nxt[2] = SumW'(p_r[8]) + SumW'(p_r[9]) + SumW'(p_r[10]) - SumW'(p_r[11]);
    c_nxt[3] = SumW'(p_r[12]) - (SumW'(p_r[13]) + SumW'(p_r[14]) + SumW'(p_r[15]));
  end

  always_comb begin
    max_nxt = mag2_r[0];
    for (int i = 1; i < 4; i++) begin
      if (mag2_r[i] > max_nxt) max_nxt = mag2_r[i];
    end
  end

  always_comb begin
    n_nxt = '0;
    for (int b = 0; b < MagW; b++) begin
      if (max3_r[b]) n_nxt = 6'(b + 1);
    end
  end

  always_comb begin
    logic [AccW-1:0] wide;
    side5_nxt.neg  = neg4_r;
    side5_nxt.zero = zero4_r;
    for (int i = 0; i < 4; i++) begin
      if (n4_r > 6'(ScaleW)) wide = AccW'(mag4_r[i]) >> (n4_r - 6'(ScaleW));
      else                   wide = AccW'(mag4_r[i]) << (6'(ScaleW) - n4_r);
      side5_nxt.mag[i] = wide[ScaleW-1:0];
    end
  end

  // integer square root, two result bits per stage
  always_comb begin
    sqrt_t cur;
    logic [AccW-1:0] bitv;
    logic [AccW-1:0] trial;
    for (int k = 0; k < SqrtStg; k++) begin
      if (k == 0) begin
        cur.side = side7_r;
        cur.rem  = s7_r;
        cur.res  = '0;
      end else begin
        cur = sq_r[k-1];
      end
      for (int j = 0; j < SqrtPer; j++) begin
        bitv  = AccW'(1) << (AccW - 2 - 2 * (SqrtPer * k + j));
        trial = cur.res + bitv;
        if (cur.rem >= trial) begin
          cur.rem = cur.rem - trial;
          cur.res = (cur.res >> 1) + bitv;
        end else begin
          cur.res = cur.res >> 1;
        end
      end
      sq_nxt[k] = cur;
    end
  end

  // restoring divide, round half up folded into the dividend
  always_comb begin
    div_t cur;
    logic [RemW-1:0] dsh;
    for (int d = 0; d < DivStg; d++) begin
      if (d == 0) begin
        cur.side = sq_r[SqrtStg-1].side;
        cur.r    = sq_r[SqrtStg-1].res[RootW-1:0];
        for (int i = 0; i < 4; i++) begin
          cur.rem[i] = (RemW'(cur.side.mag[i]) << FracBits) + RemW'(cur.r >> 1);
          cur.quo[i] = '0;
        end
      end else begin
        cur = dv_r[d-1];
      end
      for (int j = 0; j < DivPer; j++) begin
        dsh = RemW'(cur.r) << (QuoW - 1 - (DivPer * d + j));
        for (int i = 0; i < 4; i++) begin
          if (cur.rem[i] >= dsh) begin
            cur.rem[i] = cur.rem[i] - dsh;
            cur.quo[i][QuoW - 1 - (DivPer * d + j)] = 1'b1;
          end
        end
      end
      dv_nxt[d] = cur;
    end
  end

  always_comb begin
    logic [3:0][QuoW-1:0] val;
    side_t sd;
    sd = dv_r[DivStg-1].side;
    for (int i = 0; i < 4; i++) begin
      if (sd.zero)        val[i] = '0;
      else if (sd.neg[i]) val[i] = QuoW'(0) - dv_r[DivStg-1].quo[i];
      else                val[i] = dv_r[DivStg-1].quo[i];
    end
    out_nxt.prod_x      = val[0];
    out_nxt.prod_y      = val[1];
    out_nxt.prod_z      = val[2];
    out_nxt.prod_w      = val[3];
    out_nxt.zero_length = sd.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vfront_r    <= '0;
      vsq_r       <= '0;
      vdv_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vfront_r    <= {vfront_r[FrontStg-2:0], in_valid};
      vsq_r       <= {vsq_r[SqrtStg-2:0], vfront_r[FrontStg-1]};
      vdv_r       <= {vdv_r[DivStg-2:0], vsq_r[SqrtStg-1]};
      out_valid_r <= vdv_r[DivStg-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= in_data.left_w  * in_data.right_x;
      p_r[1]  <= in_data.right_w * in_data.left_x;
      p_r[2]  <= in_data.left_y  * in_data.right_z;
      p_r[3]  <= in_data.left_z  * in_data.right_y;
      p_r[4]  <= in_data.left_w  * in_data.right_y;
      p_r[5]  <= in_data.right_w * in_data.left_y;
      p_r[6]  <= in_data.left_z  * in_data.right_x;
      p_r[7]  <= in_data.left_x  * in_data.right_z;
      p_r[8]  <= in_data.left_w  * in_data.right_z;
      p_r[9]  <= in_data.right_w * in_data.left_z;
      p_r[10] <= in_data.left_x  * in_data.right_y;
      p_r[11] <= in_data.left_y  * in_data.right_x;
      p_r[12] <= in_data.left_w  * in_data.right_w;
      p_r[13] <= in_data.left_x  * in_data.right_x;
      p_r[14] <= in_data.left_y  * in_data.right_y;
      p_r[15] <= in_data.left_z  * in_data.right_z;
      for (int i = 0; i < 4; i++) begin
        neg2_r[i] <= c_nxt[i][SumW-1];
        mag2_r[i] <= c_nxt[i][SumW-1] ? MagW'(-c_nxt[i]) : MagW'(c_nxt[i]);
      end
      neg3_r  <= neg2_r;
      mag3_r  <= mag2_r;
      max3_r  <= max_nxt;
      neg4_r  <= neg3_r;
      mag4_r  <= mag3_r;
      n4_r    <= n_nxt;
      zero4_r <= (max3_r == '0);
      side5_r <= side5_nxt;
      side6_r <= side5_r;
      for (int i = 0; i < 4; i++) begin
        sq6_r[i] <= SqW'(side5_r.mag[i]) * SqW'(side5_r.mag[i]);
      end
      side7_r <= side6_r;
      s7_r    <= AccW'(sq6_r[0]) + AccW'(sq6_r[1]) + AccW'(sq6_r[2]) + AccW'(sq6_r[3]);
      for (int k = 0; k < SqrtStg; k++) sq_r[k] <= sq_nxt[k];
      for (int d = 0; d < DivStg; d++) dv_r[d] <= dv_nxt[d];
      out_r <= out_nxt;
    end
  end

endmodule

>>> src/qmn_check.sv
// port-level checker for the quaternion multiply and normalise unit, with its bind
module qmn_check
  import qmn_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a held result keeps its value until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while held");

  // zero length means every component is zero
  a_zero_comp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_length |->
      out_data.prod_x == 0 && out_data.prod_y == 0 &&
      out_data.prod_z == 0 && out_data.prod_w == 0)
    else $error("zero flag with nonzero component");

  // a unit result always has some nonzero component
  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.zero_length |->
      out_data.prod_x != 0 || out_data.prod_y != 0 ||
      out_data.prod_z != 0 || out_data.prod_w != 0)
    else $error("normalised result is all zero");

  // components never exceed one in magnitude
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.prod_x <= 16384 && out_data.prod_x >= -16384 &&
      out_data.prod_y <= 16384 && out_data.prod_y >= -16384 &&
      out_data.prod_z <= 16384 && out_data.prod_z >= -16384 &&
      out_data.prod_w <= 16384 && out_data.prod_w >= -16384)
    else $error("component beyond unit range");

  // an empty output never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind quaternion_multiply_normalize_unit qmn_check u_qmn_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> dv/testbench.sv
// testbench for the quaternion multiply and normalise unit
`timescale 1ns / 1ps

module testbench;
  import qmn_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  quaternion_multiply_normalize_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  in_t  pending_quats[$];
  out_t expected_units[$];
  int   mismatches = 0;
  int   cycle_count = 0;
  bit   stimulus_done = 1'b0;
  int   burst_left;
  int   gap_left;
  int   stall_phase;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic out_t hamilton_unit(in_t q);
    longint lx, ly, lz, lw, rx, ry, rz, rw;
    longint comp[4];
    longint unsigned mag[4];
    bit neg[4];
    longint unsigned big, sumsq, root, quo;
    int nbits;
    logic signed [15:0] lane[4];
    out_t res;
    lx = q.left_x; ly = q.left_y; lz = q.left_z; lw = q.left_w;
    rx = q.right_x; ry = q.right_y; rz = q.right_z; rw = q.right_w;
    comp[0] = lw * rx + rw * lx + (ly * rz - lz * ry);
    comp[1] = lw * ry + rw * ly + (lz * rx - lx * rz);
    comp[2] = lw * rz + rw * lz + (lx * ry - ly * rx);
    comp[3] = lw * rw - (lx * rx + ly * ry + lz * rz);
    big = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = comp[i] < 0;
      mag[i] = neg[i] ? longint'(-comp[i]) : longint'(comp[i]);
      if (mag[i] > big) big = mag[i];
    end
    res = '0;
    if (big == 0) begin
      res.zero_length = 1'b1;
      return res;
    end
    nbits = 0;
    while (nbits < 63 && (big >> nbits) != 0) nbits++;
    sumsq = 0;
    for (int i = 0; i < 4; i++) begin
      if (nbits > 31) mag[i] = mag[i] >> (nbits - 31);
      else mag[i] = mag[i] << (31 - nbits);
      sumsq = sumsq + mag[i] * mag[i];
    end
    root = root_floor(sumsq);
    for (int i = 0; i < 4; i++) begin
      quo = ((mag[i] << FracBits) + (root >> 1)) / root;
      lane[i] = neg[i] ? 16'(-quo) : 16'(quo);
    end
    res.prod_x = lane[0];
    res.prod_y = lane[1];
    res.prod_z = lane[2];
    res.prod_w = lane[3];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(16'sd16384);
      4: return 16'(-16'sd16384);
      5: return 16'($urandom_range(0, 7)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    in_t q;
    logic [15:0] edges[5];
    edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h4000};
    // all-zero, extremes, identity and other hand-picked pairs
    q = '0;
    pending_quats.push_back(q);
    q = {8{16'h8000}};
    pending_quats.push_back(q);
    q = {8{16'h7fff}};
    pending_quats.push_back(q);
    q = {8{16'hffff}};
    pending_quats.push_back(q);
    q = '0; q.left_w = 16'h4000; q.right_w = 16'h4000;
    pending_quats.push_back(q);
    q = '0; q.left_x = 16'h4000; q.right_y = 16'h4000;
    pending_quats.push_back(q);
    q = '0; q.left_x = 16'h8000; q.right_x = 16'h8000;
    pending_quats.push_back(q);
    q = '0; q.left_w = 16'h1234;
    pending_quats.push_back(q);
    q = '0; q.left_x = 16'd1; q.right_z = 16'd1;
    pending_quats.push_back(q);
    q = '0; q.left_w = 16'h7fff; q.right_w = 16'h8000;
    pending_quats.push_back(q);
    for (int i = 0; i < 10; i++) begin
      for (int k = 0; k < 8; k++) q[k*16 +: 16] = edges[$urandom_range(0, 4)];
      pending_quats.push_back(q);
    end
    for (int i = 0; i < 1250; i++) begin
      for (int k = 0; k < 8; k++) q[k*16 +: 16] = rand_comp();
      // occasionally null one operand so the product is zero
      if ($urandom_range(0, 29) == 0) q[63:0] = '0;
      pending_quats.push_back(q);
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // sender: bursts with gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_units.push_back(hamilton_unit(in_data));
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_quats.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_quats.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  // receiver: stall pattern with runs of full throughput
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 80) out_ready <= 1'b1;
      else if (stall_phase < 160) out_ready <= ($urandom_range(0, 3) != 0);
      else if (stall_phase < 200) out_ready <= ($urandom_range(0, 3) == 0);
      else out_ready <= 1'($urandom_range(0, 1));
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_units.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        want = expected_units.pop_front();
        if (out_data.prod_x !== want.prod_x)
          report_mismatch("prod_x", out_data.prod_x, want.prod_x);
        if (out_data.prod_y !== want.prod_y)
          report_mismatch("prod_y", out_data.prod_y, want.prod_y);
        if (out_data.prod_z !== want.prod_z)
          report_mismatch("prod_z", out_data.prod_z, want.prod_z);
        if (out_data.prod_w !== want.prod_w)
          report_mismatch("prod_w", out_data.prod_w, want.prod_w);
        if (out_data.zero_length !== want.zero_length)
          report_mismatch("zero_length", out_data.zero_length, want.zero_length);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done);
    while (expected_units.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
